// ===== hdl/fm_chip_timer_status_port_defines.svh =====
// ----------------------------------------------------------------------------
// FM chip timer/status port: assertion macros
// Concurrent check macros shared by the RTL files; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef FM_CHIP_TIMER_STATUS_PORT_DEFINES_SVH
`define FM_CHIP_TIMER_STATUS_PORT_DEFINES_SVH

`ifndef SYNTH

// property checked on every rising clock edge outside reset
`define FMTSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fmtsp check failed");

// condition that must hold whenever the qualifier holds
`define FMTSP_ASSERT_IMPL(lbl, clk, rst, qual, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (qual) |-> (cond)) \
      else $error("fmtsp check failed");

`else

`define FMTSP_ASSERT(lbl, clk, rst, prop)
`define FMTSP_ASSERT_IMPL(lbl, clk, rst, qual, cond)

`endif

`endif

// ===== hdl/fmtsp_pkg.sv =====
// ----------------------------------------------------------------------------
// FM chip timer/status port package
// Shared codes, constants and the timer control struct.
// ----------------------------------------------------------------------------
package fmtsp_pkg;

   localparam int CNT_W = 18;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_TICK  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      PORT_INDEX    = 2'd0,
      PORT_DATA     = 2'd1,
      PORT_INDEX_HI = 2'd2,
      PORT_DATA_HI  = 2'd3
   } port_type;

   localparam logic [1:0] CSR_OPL3_MODE = 2'd0;
   localparam logic [1:0] CSR_T1_PERIOD = 2'd1;
   localparam logic [1:0] CSR_T2_PERIOD = 2'd2;

   localparam logic [8:0] REG_TIMER1    = 9'h002;
   localparam logic [8:0] REG_TIMER2    = 9'h003;
   localparam logic [8:0] REG_TIMER_CTL = 9'h004;

   localparam logic [9:0] T1_PERIOD_RESET = 10'd80;
   localparam logic [9:0] T2_PERIOD_RESET = 10'd320;

   localparam logic [8:0]       TIMER_WRAP      = 9'h100;
   localparam logic [18:0]      SHORT_DELAY_MIN = 19'd100;
   localparam logic [CNT_W-1:0] ARM_MAX         = 18'd261889;

   localparam logic [7:0] STATUS_FAST    = 8'hC0;
   localparam logic [7:0] STATUS_SLOW    = 8'hA0;
   localparam logic [7:0] OPL2_SIGNATURE = 8'h06;
   localparam logic [7:0] FLOAT_BUS      = 8'hFF;

   // per-timer update request for one item
   typedef struct packed {
      logic       tick;        // count down one microsecond
      logic       value_we;    // store a new timer value
      logic       enable_we;   // load the enable from enable_bit
      logic       enable_bit;
      logic [7:0] data;        // new timer value
   } timer_ctl_type;

endpackage

// ===== hdl/fmtsp_timer.sv =====
// ----------------------------------------------------------------------------
// FM chip timer
// One countdown timer: value, enable, tick counter and arm arithmetic.
// ----------------------------------------------------------------------------
`include "fm_chip_timer_status_port_defines.svh"

module fmtsp_timer (
   input  logic                   clock,
   input  logic                   reset,
   input  fmtsp_pkg::timer_ctl_type ctl,
   input  logic [9:0]             period,
   output logic                   expired
);
   import fmtsp_pkg::*;

   logic [7:0]       value_ff, value_in;
   logic             enable_ff, enable_in;
   logic [CNT_W-1:0] remain_ff, remain_in;

   logic [7:0]       arm_value;
   logic [8:0]       span;
   logic [18:0]      product;
   logic [CNT_W-1:0] delay;
   logic [CNT_W-1:0] arm_count;

   // a value write arms with the new value, a control write with the stored one
   assign arm_value = ctl.value_we ? ctl.data : value_ff;
   assign span      = TIMER_WRAP - {1'b0, arm_value};
   assign product   = 19'(span) * 19'(period);
   assign delay     = (product < SHORT_DELAY_MIN) ? '0 : product[CNT_W-1:0];
   assign arm_count = delay + CNT_W'(1);

   always_comb begin
      value_in  = value_ff;
      enable_in = enable_ff;
      remain_in = remain_ff;
      if (ctl.tick) begin
         if (remain_ff != '0) begin
            remain_in = remain_ff - CNT_W'(1);
         end
      end else if (ctl.value_we) begin
         value_in = ctl.data;
         if (enable_ff) begin
            remain_in = arm_count;
         end
      end else if (ctl.enable_we) begin
         enable_in = ctl.enable_bit;
         if (ctl.enable_bit) begin
            remain_in = arm_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff  <= '0;
         enable_ff <= 1'b0;
         remain_ff <= '0;
      end else begin
         value_ff  <= value_in;
         enable_ff <= enable_in;
         remain_ff <= remain_in;
      end
   end

   assign expired = enable_ff && (remain_ff == '0);

   `FMTSP_ASSERT_IMPL(a_remain_bound, clock, reset, 1'b1, remain_ff <= ARM_MAX)
   `FMTSP_ASSERT_IMPL(a_tick_down, clock, reset, ctl.tick && (remain_ff != '0),
      ##1 (remain_ff == $past(remain_ff) - CNT_W'(1)))
   `FMTSP_ASSERT_IMPL(a_arm_nonzero, clock, reset,
      ctl.enable_we && ctl.enable_bit && !ctl.tick && !ctl.value_we,
      ##1 (enable_ff && remain_ff != '0))

endmodule

// ===== hdl/fm_chip_timer_status_port.sv =====
// ----------------------------------------------------------------------------
// FM chip timer/status port
// Host bus front end of an FM sound chip: index/data decode, two timers,
// status read and forwarding of synthesis register writes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one bus access or one microsecond tick per transfer.
//     req_tuser holds the kind (write, read, tick). req_tdata holds the port
//     offset, the written byte and the single-byte flag.
//   rsp_* returns exactly one result per request, in request order: the read
//     byte and, for a write to a non-timer register, the forwarded register
//     index and data (rsp_tuser flags a forwarded write).
//   csr_* writes the mode and the two timer periods; write only while idle.
// Path: a request accepted into the input register moves on to the result
//   register once the result register is free to load.
// Throughput: one transfer per cycle unless a held result stalls; each item's
//   decode and timer arm multiply fit between the input and result registers.
// Reset: timers disabled, counters, values and index cleared, OPL3 mode,
//   periods 80 and 320.
// Stall: a held result blocks only its register; the input register still
//   takes one more transfer, after which req_tready drops until rsp_tready.
// ----------------------------------------------------------------------------
`include "fm_chip_timer_status_port_defines.svh"

module fm_chip_timer_status_port (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] port_offset, [9:2] write_data,
                                    // [10] single_byte, [15:11] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] read_data, [16:8] fwd_reg,
                                    // [24:17] fwd_data, [31:25] zero
   output logic        rsp_tuser,   // [0] fwd_valid

   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_wdata
);
   import fmtsp_pkg::*;

   // configuration registers
   logic       opl3_mode_ff;
   logic [9:0] t1_period_ff;
   logic [9:0] t2_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opl3_mode_ff <= 1'b1;
         t1_period_ff <= T1_PERIOD_RESET;
         t2_period_ff <= T2_PERIOD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OPL3_MODE: opl3_mode_ff <= csr_wdata[0];
            CSR_T1_PERIOD: t1_period_ff <= csr_wdata;
            CSR_T2_PERIOD: t2_period_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic         in_valid_ff, in_valid_in;
   req_kind_type in_kind_ff;
   port_type     in_port_ff;
   logic [7:0]   in_data_ff;
   logic         in_single_ff;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_ff, rsp_read_in;
   logic       rsp_fwd_ff, rsp_fwd_in;
   logic [8:0] rsp_reg_ff, rsp_reg_in;
   logic [7:0] rsp_fdata_ff, rsp_fdata_in;

   logic [8:0] sel_index_ff, sel_index_in;

   logic rsp_free;    // result register can load this cycle
   logic item_go;     // item in the input register is processed
   logic req_take;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign item_go    = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || rsp_free;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !rsp_free);
   assign rsp_valid_in = item_go || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sel_index_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_index_ff <= sel_index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff   <= req_kind_type'(req_tuser);
         in_port_ff   <= port_type'(req_tdata[1:0]);
         in_data_ff   <= req_tdata[9:2];
         in_single_ff <= req_tdata[10];
      end
      if (item_go) begin
         rsp_read_ff  <= rsp_read_in;
         rsp_fwd_ff   <= rsp_fwd_in;
         rsp_reg_ff   <= rsp_reg_in;
         rsp_fdata_ff <= rsp_fdata_in;
      end
   end

   // timers
   timer_ctl_type fast_ctl, slow_ctl;
   logic          fast_expired, slow_expired;
   logic [7:0]    status;

   fmtsp_timer u_fast (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fast_ctl),
      .period  (t1_period_ff),
      .expired (fast_expired)
   );

   fmtsp_timer u_slow (
      .clock   (clock),
      .reset   (reset),
      .ctl     (slow_ctl),
      .period  (t2_period_ff),
      .expired (slow_expired)
   );

   always_comb begin
      status = '0;
      if (fast_expired) status = status | STATUS_FAST;
      if (slow_expired) status = status | STATUS_SLOW;
      if (!opl3_mode_ff) status = status | OPL2_SIGNATURE;
   end

   // item decode
   always_comb begin
      sel_index_in = sel_index_ff;
      rsp_read_in  = '0;
      rsp_fwd_in   = 1'b0;
      rsp_reg_in   = '0;
      rsp_fdata_in = '0;
      fast_ctl     = '0;
      slow_ctl     = '0;
      fast_ctl.data = in_data_ff;
      slow_ctl.data = in_data_ff;
      if (item_go) begin
         unique case (in_kind_ff)
            REQ_WRITE: begin
               if (in_single_ff) begin
                  unique case (in_port_ff)
                     PORT_INDEX:    sel_index_in = {1'b0, in_data_ff};
                     PORT_INDEX_HI: sel_index_in = {1'b1, in_data_ff};
                     default: begin
                        unique case (sel_index_ff)
                           REG_TIMER1: fast_ctl.value_we = 1'b1;
                           REG_TIMER2: slow_ctl.value_we = 1'b1;
                           REG_TIMER_CTL: begin
                              // bit 7 stops both; otherwise bits 6/5 mask
                              fast_ctl.enable_we  = in_data_ff[7] || !in_data_ff[6];
                              fast_ctl.enable_bit = !in_data_ff[7] && in_data_ff[0];
                              slow_ctl.enable_we  = in_data_ff[7] || !in_data_ff[5];
                              slow_ctl.enable_bit = !in_data_ff[7] && in_data_ff[1];
                           end
                           default: begin
                              rsp_fwd_in   = 1'b1;
                              rsp_reg_in   = sel_index_ff;
                              rsp_fdata_in = in_data_ff;
                           end
                        endcase
                     end
                  endcase
               end
            end
            REQ_READ: begin
               if (in_single_ff) begin
                  rsp_read_in = (in_port_ff == PORT_INDEX) ? status : FLOAT_BUS;
               end
            end
            REQ_TICK: begin
               fast_ctl.tick = 1'b1;
               slow_ctl.tick = 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_fdata_ff, rsp_reg_ff, rsp_read_ff};
   assign rsp_tuser  = rsp_fwd_ff;

   `FMTSP_ASSERT_IMPL(a_go_gives_rsp, clock, reset, item_go, ##1 rsp_tvalid)
   `FMTSP_ASSERT_IMPL(a_stall_full, clock, reset, !req_tready,
      in_valid_ff && rsp_valid_ff)
   `FMTSP_ASSERT_IMPL(a_fwd_not_timer, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_reg_ff != REG_TIMER1 && rsp_reg_ff != REG_TIMER2 &&
      rsp_reg_ff != REG_TIMER_CTL && rsp_read_ff == '0)
   `FMTSP_ASSERT_IMPL(a_quiet_nofwd, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_reg_ff == '0 && rsp_fdata_ff == '0)

endmodule

// ===== tb/fm_chip_timer_status_port_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FM chip timer/status port testbench
// Drives bus writes, reads and microsecond ticks into the host port. An
// in-bench copy of the index decode, the two timers and the status byte
// predicts every result, and each rsp transfer is checked against it field
// by field. A short directed part covers the reset status, ignored accesses,
// forwarding of low and high registers and a fast-timer expiry. The rest is
// random register sequences, tick bursts and noise under several timer
// period and mode settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module fm_chip_timer_status_port_tb;
   import fmtsp_pkg::*;

   // one result transfer, unpacked from rsp_tdata / rsp_tuser
   typedef struct {
      logic [7:0] read_data;
      logic       fwd_valid;
      logic [8:0] fwd_reg;
      logic [7:0] fwd_data;
   } port_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [9:0]  csr_wdata;

   // predicted port state, kept in step with every accepted transfer
   logic        mode_opl3   = 1'b1;
   logic [9:0]  fast_period = T1_PERIOD_RESET;
   logic [9:0]  slow_period = T2_PERIOD_RESET;
   logic [8:0]  cur_index   = '0;
   logic [7:0]  fast_value  = '0;
   logic [7:0]  slow_value  = '0;
   logic        fast_en     = 1'b0;
   logic        slow_en     = 1'b0;
   logic [17:0] fast_left   = '0;
   logic [17:0] slow_left   = '0;

   port_result_type pending_results[$];   // predicted results, oldest first
   int              err_count  = 0;
   int              live_items = 0;       // transfers the port actually acts on
   bit              no_idle    = 1'b0;    // both sides stream without gaps

   fm_chip_timer_status_port dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // generous bound on simulation time; a hang reports a mismatch
   initial begin
      #2_000_000;
      $display("fm_chip_timer_status_port: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Timer arithmetic: (256 - value) * period ticks, short delays collapse
   // to zero, and the counter is loaded one higher so a zero delay still
   // needs one tick before the timer reads as expired.
   // ---------------------------------------------------------------------
   function automatic logic [17:0] timer_load(logic [7:0] value, logic [9:0] period);
      logic [18:0] delay;
      delay = ({10'd0, TIMER_WRAP} - {11'd0, value}) * {9'd0, period};
      if (delay < SHORT_DELAY_MIN)
         delay = '0;
      return delay[17:0] + 18'd1;
   endfunction

   function automatic logic [7:0] status_byte();
      logic [7:0] s;
      s = '0;
      if (fast_en && fast_left == '0)
         s |= STATUS_FAST;
      if (slow_en && slow_left == '0)
         s |= STATUS_SLOW;
      if (!mode_opl3)
         s |= OPL2_SIGNATURE;
      return s;
   endfunction

   // Applies one transfer to the predicted state and returns its result.
   function automatic port_result_type port_step(req_kind_type kind, port_type port,
                                                 logic [7:0] data, logic single);
      port_result_type r;
      r = '{default: '0};
      case (kind)
         REQ_WRITE: begin
            if (single) begin
               if (port == PORT_INDEX)
                  cur_index = {1'b0, data};
               else if (port == PORT_INDEX_HI)
                  cur_index = {1'b1, data};
               else begin
                  // full 9-bit compare: 0x102..0x104 are plain registers
                  case (cur_index)
                     REG_TIMER1: begin
                        fast_value = data;
                        if (fast_en)
                           fast_left = timer_load(fast_value, fast_period);
                     end
                     REG_TIMER2: begin
                        slow_value = data;
                        if (slow_en)
                           slow_left = timer_load(slow_value, slow_period);
                     end
                     REG_TIMER_CTL: begin
                        if (data[7]) begin
                           fast_en = 1'b0;
                           slow_en = 1'b0;
                        end else begin
                           if (!data[6]) begin
                              fast_en = data[0];
                              if (fast_en)
                                 fast_left = timer_load(fast_value, fast_period);
                           end
                           if (!data[5]) begin
                              slow_en = data[1];
                              if (slow_en)
                                 slow_left = timer_load(slow_value, slow_period);
                           end
                        end
                     end
                     default: begin
                        r.fwd_valid = 1'b1;
                        r.fwd_reg   = cur_index;
                        r.fwd_data  = data;
                     end
                  endcase
               end
            end
         end
         REQ_READ: begin
            if (single)
               r.read_data = (port == PORT_INDEX) ? status_byte() : FLOAT_BUS;
         end
         REQ_TICK: begin
            if (fast_left != '0)
               fast_left--;
            if (slow_left != '0)
               slow_left--;
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result side: random backpressure and the field-by-field compare.
   // rsp_tready read here is the value from before this edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      port_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data = rsp_tdata[7:0];
         got.fwd_reg   = rsp_tdata[16:8];
         got.fwd_data  = rsp_tdata[24:17];
         got.fwd_valid = rsp_tuser;
         if (pending_results.size() == 0) begin
            $error("result transfer with no prediction pending");
            err_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, got.read_data);
               err_count++;
            end
            if (got.fwd_valid !== want.fwd_valid) begin
               $error("fwd_valid: expected %b, got %b", want.fwd_valid, got.fwd_valid);
               err_count++;
            end
            if (got.fwd_reg !== want.fwd_reg) begin
               $error("fwd_reg: expected %h, got %h", want.fwd_reg, got.fwd_reg);
               err_count++;
            end
            if (got.fwd_data !== want.fwd_data) begin
               $error("fwd_data: expected %h, got %h", want.fwd_data, got.fwd_data);
               err_count++;
            end
         end
      end
      rsp_tready <= no_idle || ($urandom_range(0, 99) >= 34);
   end

   // ---------------------------------------------------------------------
   // Request side. tvalid stays high from one transfer to the next unless
   // an idle gap is rolled; the prediction is taken at the accepting edge.
   // ---------------------------------------------------------------------
   task automatic send_item(input req_kind_type kind, input port_type port,
                            input logic [7:0] data, input logic single);
      while (!no_idle && $urandom_range(0, 99) < 34) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'd0, single, data, port};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(port_step(kind, port, data, single));
      if (kind == REQ_TICK || ((kind == REQ_WRITE || kind == REQ_READ) && single))
         live_items++;
   endtask

   // stop sending and let every predicted result come back
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (4) @(posedge clock);
   endtask

   // port must be idle; the task ends with csr_we low again so back-to-back writes never collide
   task automatic csr_write(input logic [1:0] index, input logic [9:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_OPL3_MODE: mode_opl3   = value[0];
         CSR_T1_PERIOD: fast_period = value;
         CSR_T2_PERIOD: slow_period = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Directed tests (reset configuration: OPL3, periods 80 / 320)
   // ---------------------------------------------------------------------

   // status with timers off, and the floating bus on the other offsets
   task automatic test_reset_reads();
      send_item(REQ_READ, PORT_INDEX,    8'h00, 1'b1);
      send_item(REQ_READ, PORT_DATA,     8'h00, 1'b1);
      send_item(REQ_READ, PORT_INDEX_HI, 8'h00, 1'b1);
      send_item(REQ_READ, PORT_DATA_HI,  8'hFF, 1'b1);
   endtask

   // wide accesses and the unused kind leave no trace
   task automatic test_ignored_items();
      send_item(REQ_WRITE, PORT_INDEX, 8'h55, 1'b0);
      send_item(REQ_READ,  PORT_INDEX, 8'h00, 1'b0);
      send_item(REQ_NONE,  PORT_DATA,  8'hAA, 1'b1);
   endtask

   // highest low-bank and highest high-bank index, and 0x104 which is not the timer control
   task automatic test_forwarding();
      send_item(REQ_WRITE, PORT_INDEX,    8'hFF, 1'b1);
      send_item(REQ_WRITE, PORT_DATA,     8'h00, 1'b1);
      send_item(REQ_WRITE, PORT_INDEX_HI, 8'hFF, 1'b1);
      send_item(REQ_WRITE, PORT_DATA_HI,  8'hFF, 1'b1);
      send_item(REQ_WRITE, PORT_INDEX_HI, 8'h04, 1'b1);
      send_item(REQ_WRITE, PORT_DATA,     8'hAB, 1'b1);
   endtask

   // value 0xFF at period 80 is a short delay: expired after one tick only;
   // control bit 7 then drops both enables and the status clears
   task automatic test_fast_timer();
      send_item(REQ_WRITE, PORT_INDEX, REG_TIMER1[7:0],    1'b1);
      send_item(REQ_WRITE, PORT_DATA,  8'hFF,              1'b1);
      send_item(REQ_WRITE, PORT_INDEX, REG_TIMER_CTL[7:0], 1'b1);
      send_item(REQ_WRITE, PORT_DATA,  8'h01,              1'b1);
      send_item(REQ_READ,  PORT_INDEX, 8'h00,              1'b1);
      send_item(REQ_TICK,  PORT_INDEX, 8'h00,              1'b1);
      send_item(REQ_READ,  PORT_INDEX, 8'h00,              1'b1);
      send_item(REQ_WRITE, PORT_DATA,  8'h80,              1'b1);
      send_item(REQ_READ,  PORT_INDEX, 8'h00,              1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Random traffic under one setting. Mostly well-formed index/data pairs
   // aimed at the timer registers, tick bursts and status reads; the rest
   // is forwarded writes and noise of any kind.
   // ---------------------------------------------------------------------
   task automatic test_random_traffic(input logic mode, input logic [9:0] p1,
                                      input logic [9:0] p2, input int n_items);
      int         target;
      int         pick;
      int         burst;
      logic [8:0] reg_sel;
      logic [7:0] value;
      wait_drained();
      csr_write(CSR_OPL3_MODE, {9'd0, mode});
      csr_write(CSR_T1_PERIOD, p1);
      csr_write(CSR_T2_PERIOD, p2);
      target = live_items + n_items;
      while (live_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               reg_sel = (pick < 2) ? REG_TIMER1 : (pick < 4) ? REG_TIMER2 : REG_TIMER_CTL;
            else if (pick == 7)
               reg_sel = 9'h100 | 9'($urandom_range(2, 4));
            else
               reg_sel = 9'($urandom_range(0, 511));
            send_item(REQ_WRITE, reg_sel[8] ? PORT_INDEX_HI : PORT_INDEX,
                      reg_sel[7:0], 1'b1);
            if (reg_sel == REG_TIMER_CTL)
               value = {($urandom_range(0, 7) == 0), 7'($urandom_range(0, 127))};
            else if ((reg_sel == REG_TIMER1 || reg_sel == REG_TIMER2)
                     && $urandom_range(0, 9) < 7)
               value = 8'($urandom_range(200, 255));   // short delays, many expiries
            else
               value = 8'($urandom_range(0, 255));
            send_item(REQ_WRITE, $urandom_range(0, 1) ? PORT_DATA : PORT_DATA_HI,
                      value, 1'b1);
         end else if (pick < 60) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
               send_item(REQ_TICK, port_type'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end else if (pick < 78) begin
            send_item(REQ_READ, PORT_INDEX, 8'($urandom_range(0, 255)), 1'b1);
         end else if (pick < 85) begin
            send_item(REQ_READ, port_type'($urandom_range(1, 3)),
                      8'($urandom_range(0, 255)), 1'b1);
         end else begin
            send_item(req_kind_type'($urandom_range(0, 3)),
                      port_type'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), ($urandom_range(0, 3) != 0));
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= REQ_WRITE;
      rsp_tready <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_OPL3_MODE;
      csr_wdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_reads();
      test_ignored_items();
      test_forwarding();
      test_fast_timer();

      // settings: reset values, OPL2 at fastest periods, slowest periods,
      // zero fast period, then small random periods, first streamed with no gaps, then with idling
      test_random_traffic(1'b1, T1_PERIOD_RESET, T2_PERIOD_RESET, 250);
      test_random_traffic(1'b0, 10'd1, 10'd1, 250);
      test_random_traffic(1'b1, 10'd1023, 10'd1023, 200);
      test_random_traffic(1'b0, 10'd0, 10'd2, 250);
      no_idle = 1'b1;
      test_random_traffic(1'b1, 10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)), 150);
      no_idle = 1'b0;
      test_random_traffic(1'b0, 10'($urandom_range(1, 8)), 10'($urandom_range(1, 8)), 200);

      wait_drained();
      if (err_count == 0 && pending_results.size() == 0)
         $display("fm_chip_timer_status_port: match");
      else
         $display("fm_chip_timer_status_port: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fmtsp_pkg.sv
hdl/fmtsp_timer.sv
hdl/fm_chip_timer_status_port.sv
tb/fm_chip_timer_status_port_tb.sv
